// ===== sv/mrt_pkg.sv =====
// Shared constants, types and the CRC-16/Modbus byte step for the read transaction unit.
`timescale 1ns / 1ps

package mrt_pkg;

  // Reply buffer size in bytes; valid range 8 to 256.
  localparam int BUFFER_DEPTH = 256;
  localparam int ADDR_W       = $clog2(BUFFER_DEPTH);
  localparam int LEN_W        = $clog2(BUFFER_DEPTH + 1);

  // Command queue between the front and back parts.
  localparam int QUEUE_DEPTH  = 4;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

  // Input function codes.
  localparam logic [1:0] FUNC_START = 2'd0;
  localparam logic [1:0] FUNC_RX    = 2'd1;
  localparam logic [1:0] FUNC_END   = 2'd2;
  localparam logic [1:0] FUNC_READ  = 2'd3;

  // Result kinds, also used as command kinds in the queue.
  localparam logic [1:0] KIND_REQ    = 2'd0;
  localparam logic [1:0] KIND_STATUS = 2'd1;
  localparam logic [1:0] KIND_READ   = 2'd2;

  localparam logic [15:0] CRC_INIT       = 16'hFFFF;
  localparam logic [15:0] CRC_POLY       = 16'hA001;
  localparam logic [7:0]  MB_FUNC_READ   = 8'h03;
  localparam logic [7:0]  LEAD_ZERO      = 8'h00;
  localparam int          FRAME_OVERHEAD = 5;
  localparam int          REQ_BEATS      = 8;
  localparam int          BEAT_W         = $clog2(REQ_BEATS);

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  data;
    logic        ok;
    logic [7:0]  cnt;
    logic [7:0]  addr;
    logic [15:0] first;
    logic [15:0] count;
  } cmd_t;

  typedef struct packed {
    logic pop;
    logic mid_request;
  } bk_stat_t;

  // One byte of CRC-16/Modbus, reflected, LSB first.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ===== sv/modbus_rtu_read_transaction_unit.sv =====
// A result passes through the front command register, the command queue and the back output register.
// Throughput: one item per cycle while in_stall is low; a start item's eight request bytes leave
// one per cycle while out_stall is low, so the 8-beat back-part request sequencer sets their rate.
// Receive items produce no result and never wait on the back part unless the queue is full.
// Reset (rst_n low, synchronous) empties the queue and pipeline and restores the initial state;
// the reply buffer itself is not cleared, since only written bytes are ever read back.
`timescale 1ns / 1ps

module modbus_rtu_read_transaction_unit
  import mrt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_func,
  input  logic [7:0]  in_slave_address,
  input  logic [15:0] in_first_register,
  input  logic [15:0] in_register_count,
  input  logic [7:0]  in_rx_byte,
  input  logic [7:0]  in_read_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_byte,
  output logic        out_last,
  output logic        out_frame_ok,
  output logic [7:0]  out_data_count
);

  // The front part takes every input transfer. Receive bytes are written to the
  // reply buffer and folded into a CRC that runs two bytes behind, so that at the
  // end of the reply it covers everything except the trailing CRC. Start, end and
  // read items become commands; the end check and the buffer read happen in the
  // front so that later receive bytes cannot disturb them.
  logic     q_full;
  logic     push_valid;
  cmd_t     push_cmd;
  logic     q_head_valid;
  cmd_t     q_head;
  bk_stat_t bk_stat;

  mrt_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_func           (in_func),
    .in_slave_address  (in_slave_address),
    .in_first_register (in_first_register),
    .in_register_count (in_register_count),
    .in_rx_byte        (in_rx_byte),
    .in_read_index     (in_read_index),
    .q_full            (q_full),
    .push_valid        (push_valid),
    .push_cmd          (push_cmd)
  );

  // A short queue lets the front keep accepting while the back part sends the
  // eight bytes of a request or waits on a stalled output.
  mrt_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .pop        (bk_stat.pop),
    .head_valid (q_head_valid),
    .head_cmd   (q_head)
  );

  // The back part turns each command into result transfers through a single
  // output register; a request command stays at the head of the queue until its
  // last byte has been loaded.
  mrt_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head_valid     (q_head_valid),
    .head_cmd       (q_head),
    .stat           (bk_stat),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_kind       (out_kind),
    .out_byte       (out_byte),
    .out_last       (out_last),
    .out_frame_ok   (out_frame_ok),
    .out_data_count (out_data_count)
  );

`ifndef SYNTHESIS
  // Part way through a request, the head of the queue must still be that request.
  a_mid_request_head: assert property (@(posedge clk) disable iff (!rst_n)
    bk_stat.mid_request |-> (q_head_valid && (q_head.kind == KIND_REQ)))
    else $error("request sequencer running without a request at the queue head");

  // The back part never pops an empty queue.
  a_no_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
    bk_stat.pop |-> q_head_valid)
    else $error("pop from an empty command queue");

  // Only request bytes carry the last flag.
  a_last_is_request: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |-> (out_kind == KIND_REQ))
    else $error("last flag on a result that is not a request byte");

  // A passing frame status always reports an even byte count.
  a_ok_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_frame_ok) |-> ((out_kind == KIND_STATUS) && !out_data_count[0]))
    else $error("frame ok on a result that is not a well-formed status");
`endif

endmodule

// ===== sv/mrt_queue.sv =====
// Small command queue that decouples the front part from the back part.
`timescale 1ns / 1ps

module mrt_queue
  import mrt_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output cmd_t head_cmd
);

  cmd_t              q_mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              push_ok;
  logic              pop_ok;

  assign full       = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_cmd   = q_mem_r[rd_ptr_r];
  assign push_ok    = push_valid && !full;
  assign pop_ok     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push_ok) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop_ok) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push_ok && !pop_ok) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop_ok && !push_ok) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      q_mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// ===== sv/mrt_front.sv =====
// Front part: accepts items, tracks the reply buffer, CRC and checks, and issues commands.
`timescale 1ns / 1ps

module mrt_front
  import mrt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_func,
  input  logic [7:0]  in_slave_address,
  input  logic [15:0] in_first_register,
  input  logic [15:0] in_register_count,
  input  logic [7:0]  in_rx_byte,
  input  logic [7:0]  in_read_index,
  input  logic        q_full,
  output logic        push_valid,
  output cmd_t        push_cmd
);

  logic [7:0]       rx_store_r [BUFFER_DEPTH];
  logic [7:0]       rd_data_r;
  logic [7:0]       hd_r [4];

  logic [LEN_W-1:0] rx_len_r, rx_len_nxt;
  logic [15:0]      crc_r, crc_nxt;
  logic [15:0]      tail_r, tail_nxt;
  logic             lzp_r, lzp_nxt;
  logic [7:0]       target_addr_r, target_addr_nxt;
  logic [15:0]      target_count_r, target_count_nxt;
  logic             reply_valid_r, reply_valid_nxt;

  logic             b_valid_r, b_valid_nxt;
  cmd_t             b_cmd_r, b_cmd_nxt;
  logic             b_hit_r, b_hit_nxt;

  logic             accept;
  logic             a_load;
  logic             rx_take;
  logic             rd_en;
  logic [8:0]       rd_idx;
  logic [7:0]       fa0, fa1, fa2;
  logic [LEN_W-1:0] len_f;
  logic [15:0]      rcv_crc;
  logic             frame_ok;
  logic             rd_hit;

  assign in_stall = b_valid_r && q_full;
  assign accept   = in_valid && !in_stall;
  assign a_load   = accept && (in_func != FUNC_RX);
  assign rx_take  = accept && (in_func == FUNC_RX) && (rx_len_r < LEN_W'(BUFFER_DEPTH));

  // Frame view skips a discarded leading zero.
  assign fa0     = lzp_r ? hd_r[1] : hd_r[0];
  assign fa1     = lzp_r ? hd_r[2] : hd_r[1];
  assign fa2     = lzp_r ? hd_r[3] : hd_r[2];
  assign len_f   = rx_len_r - LEN_W'(lzp_r);
  assign rcv_crc = {tail_r[7:0], tail_r[15:8]};

  assign frame_ok = (len_f >= LEN_W'(FRAME_OVERHEAD)) &&
                    (crc_r == rcv_crc) &&
                    (fa0 == target_addr_r) &&
                    (fa1 == MB_FUNC_READ) &&
                    (17'(fa2) == {target_count_r, 1'b0}) &&
                    (10'(len_f) == 10'(fa2) + 10'(FRAME_OVERHEAD));

  assign rd_hit = reply_valid_r && (in_read_index < fa2);
  assign rd_idx = 9'(in_read_index) + 9'd3 + 9'(lzp_r);
  assign rd_en  = accept && (in_func == FUNC_READ) && rd_hit;

  always_comb begin
    rx_len_nxt       = rx_len_r;
    crc_nxt          = crc_r;
    tail_nxt         = tail_r;
    lzp_nxt          = lzp_r;
    target_addr_nxt  = target_addr_r;
    target_count_nxt = target_count_r;
    reply_valid_nxt  = reply_valid_r;
    b_cmd_nxt        = b_cmd_r;
    b_hit_nxt        = b_hit_r;
    b_valid_nxt      = b_valid_r;

    if (rx_take) begin
      if ((rx_len_r == LEN_W'(1)) && (hd_r[0] == LEAD_ZERO) &&
          (in_rx_byte == target_addr_r)) begin
        lzp_nxt = 1'b1;
      end
      // The CRC trails the newest byte by two, so the received CRC never enters it.
      if ((rx_len_r >= LEN_W'(2)) && !((rx_len_r == LEN_W'(2)) && lzp_r)) begin
        crc_nxt = crc_byte(crc_r, tail_r[15:8]);
      end
      tail_nxt   = {tail_r[7:0], in_rx_byte};
      rx_len_nxt = rx_len_r + 1'b1;
    end

    if (accept && (in_func == FUNC_START)) begin
      target_addr_nxt  = in_slave_address;
      target_count_nxt = in_register_count;
      rx_len_nxt       = '0;
      crc_nxt          = CRC_INIT;
      tail_nxt         = '0;
      lzp_nxt          = 1'b0;
      reply_valid_nxt  = 1'b0;
    end

    if (accept && (in_func == FUNC_END)) begin
      reply_valid_nxt = frame_ok;
    end

    if (!b_valid_r || !q_full) begin
      b_valid_nxt = a_load;
      if (a_load) begin
        b_cmd_nxt       = '0;
        b_hit_nxt       = 1'b0;
        case (in_func)
          FUNC_START: begin
            b_cmd_nxt.kind  = KIND_REQ;
            b_cmd_nxt.addr  = in_slave_address;
            b_cmd_nxt.first = in_first_register;
            b_cmd_nxt.count = in_register_count;
          end
          FUNC_END: begin
            b_cmd_nxt.kind = KIND_STATUS;
            b_cmd_nxt.ok   = frame_ok;
            b_cmd_nxt.cnt  = frame_ok ? fa2 : 8'h00;
          end
          FUNC_READ: begin
            b_cmd_nxt.kind = KIND_READ;
            b_hit_nxt      = rd_hit;
          end
          default: begin
            b_cmd_nxt = '0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx_len_r       <= '0;
      crc_r          <= CRC_INIT;
      tail_r         <= '0;
      lzp_r          <= 1'b0;
      target_addr_r  <= '0;
      target_count_r <= '0;
      reply_valid_r  <= 1'b0;
      b_valid_r      <= 1'b0;
    end else begin
      rx_len_r       <= rx_len_nxt;
      crc_r          <= crc_nxt;
      tail_r         <= tail_nxt;
      lzp_r          <= lzp_nxt;
      target_addr_r  <= target_addr_nxt;
      target_count_r <= target_count_nxt;
      reply_valid_r  <= reply_valid_nxt;
      b_valid_r      <= b_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    b_cmd_r <= b_cmd_nxt;
    b_hit_r <= b_hit_nxt;
    if (rx_take && (rx_len_r < LEN_W'(4))) begin
      hd_r[rx_len_r[1:0]] <= in_rx_byte;
    end
  end

  // Reply buffer: one write or one registered read per cycle.
  always_ff @(posedge clk) begin
    if (rx_take) begin
      rx_store_r[rx_len_r[ADDR_W-1:0]] <= in_rx_byte;
    end
    if (rd_en) begin
      rd_data_r <= rx_store_r[rd_idx[ADDR_W-1:0]];
    end
  end

  always_comb begin
    push_cmd = b_cmd_r;
    if (b_hit_r) begin
      push_cmd.data = rd_data_r;
    end
  end

  assign push_valid = b_valid_r;

endmodule

// ===== sv/mrt_back.sv =====
// Back part: executes queued commands and drives the registered result channel.
`timescale 1ns / 1ps

module mrt_back
  import mrt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        head_valid,
  input  cmd_t        head_cmd,
  output bk_stat_t    stat,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_byte,
  output logic        out_last,
  output logic        out_frame_ok,
  output logic [7:0]  out_data_count
);

  logic [BEAT_W-1:0] beat_r, beat_nxt;
  logic [15:0]       crc_r, crc_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [1:0]        kind_r, kind_nxt;
  logic [7:0]        byte_r, byte_nxt;
  logic              last_r, last_nxt;
  logic              ok_r, ok_nxt;
  logic [7:0]        cnt_r, cnt_nxt;

  logic              load;
  logic [7:0]        req_byte;
  logic              req_last;

  assign load = head_valid && (!out_valid_r || !out_stall);
  assign req_last = (beat_r == BEAT_W'(REQ_BEATS - 1));

  always_comb begin
    case (beat_r)
      3'd0:    req_byte = head_cmd.addr;
      3'd1:    req_byte = MB_FUNC_READ;
      3'd2:    req_byte = head_cmd.first[15:8];
      3'd3:    req_byte = head_cmd.first[7:0];
      3'd4:    req_byte = head_cmd.count[15:8];
      3'd5:    req_byte = head_cmd.count[7:0];
      3'd6:    req_byte = crc_r[7:0];
      default: req_byte = crc_r[15:8];
    endcase
  end

  always_comb begin
    beat_nxt         = beat_r;
    crc_nxt          = crc_r;
    kind_nxt         = kind_r;
    byte_nxt         = byte_r;
    last_nxt         = last_r;
    ok_nxt           = ok_r;
    cnt_nxt          = cnt_r;
    out_valid_nxt    = out_valid_r && out_stall;
    stat.pop         = 1'b0;
    stat.mid_request = (beat_r != '0);

    if (load) begin
      out_valid_nxt = 1'b1;
      kind_nxt      = head_cmd.kind;
      byte_nxt      = 8'h00;
      last_nxt      = 1'b0;
      ok_nxt        = 1'b0;
      cnt_nxt       = 8'h00;
      if (head_cmd.kind == KIND_REQ) begin
        byte_nxt = req_byte;
        last_nxt = req_last;
        // The request CRC is built one byte per beat as the header goes out.
        if (beat_r < BEAT_W'(6)) begin
          crc_nxt = crc_byte((beat_r == '0) ? CRC_INIT : crc_r, req_byte);
        end
        beat_nxt = req_last ? '0 : beat_r + 1'b1;
        stat.pop = req_last;
      end else begin
        byte_nxt = head_cmd.data;
        ok_nxt   = head_cmd.ok;
        cnt_nxt  = head_cmd.cnt;
        stat.pop = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beat_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      beat_r      <= beat_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    crc_r  <= crc_nxt;
    kind_r <= kind_nxt;
    byte_r <= byte_nxt;
    last_r <= last_nxt;
    ok_r   <= ok_nxt;
    cnt_r  <= cnt_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = kind_r;
  assign out_byte         = byte_r;
  assign out_last         = last_r;
  assign out_frame_ok     = ok_r;
  assign out_data_count   = cnt_r;

endmodule
